/* hdl/upd_pkg.sv */
// package for the url percent decoder: item types, character codes, hex helpers
`timescale 1ns / 1ps
`default_nettype none
package upd_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_out;
  } out_item_t;

  // up to three bytes to emit for one input character, last flag on the final one
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic            last;
  } cmd_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_PCT,
    PEND_HEX
  } pend_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CHAR_0) && (c <= CHAR_9);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = is_digit(c) || ((c >= CHAR_LA) && (c <= CHAR_LF)) ||
             ((c >= CHAR_UA) && (c <= CHAR_UF));
  endfunction

  // letters a-f and A-F have low nibble 1..6
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    hex_val = is_digit(c) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

endpackage
`default_nettype wire

/* hdl/upd_front.sv */
// front part: holds escape state and turns each character into an emit command
`timescale 1ns / 1ps
`default_nettype none
module upd_front
  import upd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire in_item_t item,
  output cmd_t          cmd
);

  pend_t      pend, pend_next;
  logic [7:0] hold, hold_next;

  logic [7:0] c;
  logic       c_hex;
  logic       pl_emit;
  logic [7:0] pl_byte;

  assign c     = item.char_in;
  assign c_hex = is_hex(c);

  // handling of a character when nothing is pending
  always_comb begin
    pl_emit = 1'b1;
    pl_byte = c;
    if (c == CHAR_PCT) begin
      pl_emit = item.last_in;
    end else if (c == CHAR_PLUS) begin
      pl_byte = CHAR_SPACE;
    end
  end

  always_comb begin
    pend_next = pend;
    hold_next = hold;
    case (pend)
      PEND_PCT: begin
        if (c_hex && !item.last_in) begin
          pend_next = PEND_HEX;
          hold_next = c;
        end else if (!c_hex && c == CHAR_PCT && !item.last_in) begin
          pend_next = PEND_PCT;
        end else begin
          pend_next = PEND_NONE;
        end
      end
      PEND_HEX: begin
        if (!c_hex && c == CHAR_PCT && !item.last_in) begin
          pend_next = PEND_PCT;
        end else begin
          pend_next = PEND_NONE;
        end
      end
      default: begin
        if (c == CHAR_PCT && !item.last_in) begin
          pend_next = PEND_PCT;
        end else begin
          pend_next = PEND_NONE;
        end
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.last  = item.last_in;
    case (pend)
      PEND_PCT: begin
        cmd.bytes[0] = CHAR_PCT;
        if (c_hex) begin
          if (item.last_in) begin
            cmd.count    = 2'd2;
            cmd.bytes[1] = c;
          end
        end else begin
          cmd.bytes[1] = pl_byte;
          cmd.count    = pl_emit ? 2'd2 : 2'd1;
        end
      end
      PEND_HEX: begin
        if (c_hex) begin
          cmd.count    = 2'd1;
          cmd.bytes[0] = {hex_val(hold), hex_val(c)};
        end else begin
          cmd.bytes[0] = CHAR_PCT;
          cmd.bytes[1] = hold;
          cmd.bytes[2] = pl_byte;
          cmd.count    = pl_emit ? 2'd3 : 2'd2;
        end
      end
      default: begin
        cmd.bytes[0] = pl_byte;
        cmd.count    = pl_emit ? 2'd1 : 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= PEND_NONE;
      hold <= '0;
    end else if (accept) begin
      pend <= pend_next;
      hold <= hold_next;
    end
  end

`ifndef SYNTHESIS
  a_hold_is_hex: assert property (@(posedge clk) disable iff (rst)
    pend == PEND_HEX |-> is_hex(hold))
    else $error("held digit of a pending escape is not a hex digit");
`endif

endmodule
`default_nettype wire

/* hdl/upd_queue.sv */
// short command queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module upd_queue
  import upd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output cmd_t      rd_data,
  output logic      avail
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign avail   = (count != '0);
  assign rd_data = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("command written into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> avail)
    else $error("command read from an empty queue");
`endif

endmodule
`default_nettype wire

/* hdl/upd_back.sv */
// back part: plays out the bytes of each command, one per transfer
`timescale 1ns / 1ps
`default_nettype none
module upd_back
  import upd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic avail,
  input  wire cmd_t next_cmd,
  output logic      take,
  input  wire logic pop,
  output logic      empty,
  output out_item_t out_item
);

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       at_end;
  logic       xfer;

  assign at_end = (idx == cur.count - 2'd1);
  assign xfer   = pop && cur_valid;
  assign take   = avail && (!cur_valid || (xfer && at_end));
  assign empty  = !cur_valid;

  assign out_item.byte_out = cur.bytes[idx];
  assign out_item.last_out = cur.last && at_end;

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= next_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (take) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (xfer) begin
        if (at_end) begin
          cur_valid <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_cmd_nonzero: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.count != 2'd0 && idx < cur.count))
    else $error("byte index outside the current command");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    xfer && !at_end |=> cur_valid && idx == $past(idx) + 2'd1)
    else $error("byte index did not advance after a transfer");
`endif

endmodule
`default_nettype wire

/* hdl/url_percent_decoder.sv */
// top level of the url percent decoder
//
//   channel   direction  handshake          payload
//   in_item   in         push / full        char_in, last_in
//   out_item  out        pop / empty        byte_out, last_out
//
// one character is taken per cycle while the command queue has room
// each character yields zero to three bytes; the back part sends one byte per cycle
// while pop is high, so a broken escape keeps it busy for up to three bytes
// first byte of a character goes into the queue, then into cur, before it is on out_item
// rst clears the escape state, the queue and the output stage
// a stall on the output side fills the queue, then full goes high
`timescale 1ns / 1ps
`default_nettype none
module url_percent_decoder
  import upd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_item
);

  logic accept;
  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_avail;
  logic q_take;

  assign accept = push && !full;

  upd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_item),
    .cmd    (front_cmd)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && front_cmd.count != 2'd0),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (q_take),
    .rd_data (q_cmd),
    .avail   (q_avail)
  );

  upd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (q_avail),
    .next_cmd (q_cmd),
    .take     (q_take),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

/* bench/upd_decode_check.sv */
// watches both queue ports of the url percent decoder, predicts decoded bytes and compares
`timescale 1ns / 1ps
module upd_decode_check
  import upd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire logic      full,
  input  wire in_item_t  in_item,
  input  wire logic      empty,
  input  wire logic      pop,
  input  wire out_item_t out_item,
  output int             errors,
  output int             awaiting
);

  out_item_t  decoded_q[$];
  pend_t      held_state;
  logic [7:0] held_digit;
  out_item_t  want;

  // digit value 0..15, or -1 for anything that is not a hex digit
  function automatic int digit_value(input logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
    if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - CHAR_LA) + 10;
    if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + 10;
    return -1;
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic l);
    decoded_q.push_back('{byte_out: b, last_out: l});
  endtask

  // character seen with no escape in progress
  task automatic take_plain(input logic [7:0] c, input logic l);
    if (c == CHAR_PCT) begin
      if (l) add_byte(CHAR_PCT, 1'b1);
      else held_state = PEND_PCT;
    end else if (c == CHAR_PLUS) begin
      add_byte(CHAR_SPACE, l);
    end else begin
      add_byte(c, l);
    end
  endtask

  task automatic decode_char(input logic [7:0] c, input logic l);
    int v;
    int hi;
    v = digit_value(c);
    case (held_state)
      PEND_PCT: begin
        if (v >= 0) begin
          if (l) begin
            // string ends after '%' and one digit: flush both
            held_state = PEND_NONE;
            add_byte(CHAR_PCT, 1'b0);
            add_byte(c, 1'b1);
          end else begin
            held_state = PEND_HEX;
            held_digit = c;
          end
        end else begin
          held_state = PEND_NONE;
          add_byte(CHAR_PCT, 1'b0);
          take_plain(c, l);
        end
      end
      PEND_HEX: begin
        held_state = PEND_NONE;
        if (v >= 0) begin
          hi = digit_value(held_digit);
          if (hi < 0) hi = 0;
          add_byte(8'(16 * hi + v), l);
        end else begin
          // broken escape: '%' and the held digit go out as they are
          add_byte(CHAR_PCT, 1'b0);
          add_byte(held_digit, 1'b0);
          take_plain(c, l);
        end
      end
      default: begin
        held_state = PEND_NONE;
        take_plain(c, l);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_state = PEND_NONE;
      held_digit = '0;
      decoded_q.delete();
      errors = 0;
    end else begin
      // output side first so a byte never matches a prediction made in the same cycle
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected byte transfer, expected none, got byte %h last %b",
                   $time, out_item.byte_out, out_item.last_out);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (out_item.byte_out !== want.byte_out) begin
            $display("%0t: byte_out expected %h got %h", $time, want.byte_out,
                     out_item.byte_out);
            errors++;
          end
          if (out_item.last_out !== want.last_out) begin
            $display("%0t: last_out expected %b got %b", $time, want.last_out,
                     out_item.last_out);
            errors++;
          end
        end
      end
      if (push && !full) decode_char(in_item.char_in, in_item.last_in);
    end
    awaiting = decoded_q.size();
  end

endmodule

/* bench/url_percent_decoder_tb.sv */
// testbench top for the url percent decoder: stimulus, output stalls and verdict
`timescale 1ns / 1ps
module url_percent_decoder_tb;
  import upd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int ITEM_TARGET  = 280;
  localparam int IDLE_PCT     = 22;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic      clk     = 1'b0;
  logic      rst     = 1'b1;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  out_item_t out_item;
  int        errors;
  int        awaiting;
  int        chars_sent = 0;
  int        cycle = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  url_percent_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  upd_decode_check decode_check (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .errors   (errors),
    .awaiting (awaiting)
  );

  // receiver stalls at random, except for a stretch of steady draining
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst) pop <= 1'b0;
    else if (chars_sent >= 60 && chars_sent < 150) pop <= 1'b1;
    else pop <= ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (cycle == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_LA && c <= CHAR_LF) ||
           (c >= CHAR_UA && c <= CHAR_UF);
  endfunction

  function automatic logic [7:0] hex_char();
    int d;
    d = $urandom_range(15);
    if (d < 10) return CHAR_0 + 8'(d);
    return ($urandom_range(1) ? CHAR_LA : CHAR_UA) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (is_hex_char(c));
    return c;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CHAR_PCT);
    return c;
  endfunction

  // one character transfer; the sender idles at random outside its steady stretch
  task automatic send_char(input logic [7:0] c, input logic l);
    while (!(chars_sent >= 150 && chars_sent < 230) && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= '{char_in: c, last_in: l};
    // full only changes at a rising edge, so the falling edge shows what the next edge sees
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // mostly well-formed strings with escapes, some broken escapes and raw noise
  task automatic send_random_string();
    logic [7:0] text[$];
    int len;
    len = $urandom_range(1, 10);
    if ($urandom_range(9) == 0) begin
      repeat (len) text.push_back(8'($urandom_range(1, 255)));
    end else begin
      while (text.size() < len) begin
        case ($urandom_range(7))
          0, 1: text.push_back(plain_char());
          2: text.push_back(CHAR_PLUS);
          3, 4: begin
            text.push_back(CHAR_PCT);
            text.push_back(hex_char());
            text.push_back(hex_char());
          end
          5: begin
            text.push_back(CHAR_PCT);
            text.push_back(non_hex_char());
          end
          6: begin
            text.push_back(CHAR_PCT);
            text.push_back(hex_char());
            text.push_back(non_hex_char());
          end
          default: text.push_back(8'($urandom_range(1, 255)));
        endcase
      end
      // sometimes the string stops in the middle of an escape
      case ($urandom_range(5))
        0: text.push_back(CHAR_PCT);
        1: begin
          text.push_back(CHAR_PCT);
          text.push_back(hex_char());
        end
        default: ;
      endcase
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_text("%41");
    send_text("%fF+");
    send_text("%00");
    send_text("%4z%%");
    send_text("%a");
    send_text("%");
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b1);
    send_text("%3%41");

    while (chars_sent < ITEM_TARGET / 2) send_random_string();
    // hold off until every decoded byte has come out
    push <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    @(posedge clk);
    while (chars_sent < ITEM_TARGET) send_random_string();

    push <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
